@@ hdl/arb_pkg.sv @@
// Shared types, register indexes and helpers for the affine rectangle bounds block.
// No dependencies; imported by every module under hdl/.
package arb_pkg;

   localparam int NCORNER = 4;
   localparam int QFRAC   = 16;

   typedef logic signed [31:0] q16_type;
   typedef logic signed [48:0] hsum_type;
   typedef logic [2:0]         csr_index_type;

   localparam csr_index_type CSR_COEF_XX  = 3'd0;
   localparam csr_index_type CSR_COEF_XY  = 3'd1;
   localparam csr_index_type CSR_OFFSET_X = 3'd2;
   localparam csr_index_type CSR_COEF_YX  = 3'd3;
   localparam csr_index_type CSR_COEF_YY  = 3'd4;
   localparam csr_index_type CSR_OFFSET_Y = 3'd5;

   localparam q16_type Q16_ONE  = 32'sd65536;
   localparam q16_type Q16_ZERO = 32'sd0;

   typedef struct packed {
      q16_type xx;
      q16_type xy;
      q16_type off_x;
      q16_type yx;
      q16_type yy;
      q16_type off_y;
   } coef_type;

   typedef struct packed {
      q16_type left;
      q16_type right;
      q16_type top;
      q16_type bottom;
   } corner_type;

   typedef struct packed {
      logic signed [63:0] xx_l;
      logic signed [63:0] xx_r;
      logic signed [63:0] xy_t;
      logic signed [63:0] xy_b;
      logic signed [63:0] yx_l;
      logic signed [63:0] yx_r;
      logic signed [63:0] yy_t;
      logic signed [63:0] yy_b;
   } prod_type;

   // pipeline control shared by every stage
   typedef struct packed {
      logic en;
      logic valid;
   } stage_ctl_type;

   // saturate a 50-bit signed value to signed 32 bits
   function automatic q16_type sat_s32(input logic signed [49:0] v);
      q16_type r;
      if ((v[49:31] == '0) || (v[49:31] == '1)) begin
         r = v[31:0];
      end else if (v[49]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7FFF_FFFF;
      end
      return r;
   endfunction

endpackage

@@ hdl/arb_corner.sv @@
// Stage 1: far edges of the rectangle, saturated to Q16.16.
// Depends on arb_pkg.
module arb_corner (
   input  logic                   clock,
   input  logic                   reset,
   input  arb_pkg::stage_ctl_type ctl,
   input  arb_pkg::q16_type       rect_left,
   input  arb_pkg::q16_type       rect_top,
   input  arb_pkg::q16_type       rect_width,
   input  arb_pkg::q16_type       rect_height,
   output logic                   valid_ff,
   output arb_pkg::corner_type    corner_ff
);
   import arb_pkg::*;

   logic signed [32:0] right_sum;
   logic signed [32:0] bottom_sum;
   corner_type         corner_in;

   always_comb begin
      right_sum         = 33'(rect_left) + 33'(rect_width);
      bottom_sum        = 33'(rect_top) + 33'(rect_height);
      corner_in.left    = rect_left;
      corner_in.top     = rect_top;
      corner_in.right   = sat_s32(50'(right_sum));
      corner_in.bottom  = sat_s32(50'(bottom_sum));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.en) begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         corner_ff <= corner_in;
      end
   end

endmodule

@@ hdl/arb_mul.sv @@
// Stage 2: the eight coefficient-by-edge products, one 32x32 multiplier each.
// Depends on arb_pkg.
module arb_mul (
   input  logic                   clock,
   input  logic                   reset,
   input  arb_pkg::stage_ctl_type ctl,
   input  arb_pkg::coef_type      coef,
   input  arb_pkg::corner_type    corner,
   output logic                   valid_ff,
   output arb_pkg::prod_type      prod_ff
);
   import arb_pkg::*;

   prod_type prod_in;

   // corners share edges, so x and y products pair up per corner later
   always_comb begin
      prod_in.xx_l = coef.xx * corner.left;
      prod_in.xx_r = coef.xx * corner.right;
      prod_in.xy_t = coef.xy * corner.top;
      prod_in.xy_b = coef.xy * corner.bottom;
      prod_in.yx_l = coef.yx * corner.left;
      prod_in.yx_r = coef.yx * corner.right;
      prod_in.yy_t = coef.yy * corner.top;
      prod_in.yy_b = coef.yy * corner.bottom;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.en) begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         prod_ff <= prod_in;
      end
   end

endmodule

@@ hdl/arb_map.sv @@
// Stages 3-4: per-corner product sum with floor shift, then offset and saturation.
// Depends on arb_pkg.
module arb_map (
   input  logic                   clock,
   input  logic                   reset,
   input  arb_pkg::stage_ctl_type ctl,
   input  arb_pkg::coef_type      coef,
   input  arb_pkg::prod_type      prod,
   output logic                   valid_ff,
   output arb_pkg::q16_type       map_x_ff [arb_pkg::NCORNER],
   output arb_pkg::q16_type       map_y_ff [arb_pkg::NCORNER]
);
   import arb_pkg::*;

   logic signed [63:0] ax [NCORNER];
   logic signed [63:0] bx [NCORNER];
   logic signed [63:0] ay [NCORNER];
   logic signed [63:0] by [NCORNER];
   hsum_type           hx_in [NCORNER];
   hsum_type           hy_in [NCORNER];
   hsum_type           hx_ff [NCORNER];
   hsum_type           hy_ff [NCORNER];
   q16_type            map_x_in [NCORNER];
   q16_type            map_y_in [NCORNER];
   logic               mid_valid_ff;
   logic signed [64:0] sx;
   logic signed [64:0] sy;
   logic signed [49:0] vx;
   logic signed [49:0] vy;

   // corner order: (l,t) (l,b) (r,t) (r,b)
   assign ax[0] = prod.xx_l;  assign bx[0] = prod.xy_t;
   assign ax[1] = prod.xx_l;  assign bx[1] = prod.xy_b;
   assign ax[2] = prod.xx_r;  assign bx[2] = prod.xy_t;
   assign ax[3] = prod.xx_r;  assign bx[3] = prod.xy_b;
   assign ay[0] = prod.yx_l;  assign by[0] = prod.yy_t;
   assign ay[1] = prod.yx_l;  assign by[1] = prod.yy_b;
   assign ay[2] = prod.yx_r;  assign by[2] = prod.yy_t;
   assign ay[3] = prod.yx_r;  assign by[3] = prod.yy_b;

   // exact sum, then drop the fraction bits (floor)
   always_comb begin
      for (int i = 0; i < NCORNER; i++) begin
         sx       = 65'(ax[i]) + 65'(bx[i]);
         sy       = 65'(ay[i]) + 65'(by[i]);
         hx_in[i] = sx[64:QFRAC];
         hy_in[i] = sy[64:QFRAC];
      end
   end

   always_comb begin
      for (int i = 0; i < NCORNER; i++) begin
         vx          = 50'(hx_ff[i]) + 50'(coef.off_x);
         vy          = 50'(hy_ff[i]) + 50'(coef.off_y);
         map_x_in[i] = sat_s32(vx);
         map_y_in[i] = sat_s32(vy);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         valid_ff     <= 1'b0;
      end else if (ctl.en) begin
         mid_valid_ff <= ctl.valid;
         valid_ff     <= mid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         hx_ff    <= hx_in;
         hy_ff    <= hy_in;
         map_x_ff <= map_x_in;
         map_y_ff <= map_y_in;
      end
   end

endmodule

@@ hdl/arb_bbox.sv @@
// Stages 5-7: min/max tree over the mapped corners, then saturated extents.
// Depends on arb_pkg.
module arb_bbox (
   input  logic                   clock,
   input  logic                   reset,
   input  arb_pkg::stage_ctl_type ctl,
   input  arb_pkg::q16_type       map_x [arb_pkg::NCORNER],
   input  arb_pkg::q16_type       map_y [arb_pkg::NCORNER],
   output logic                   valid_ff,
   output arb_pkg::q16_type       box_left_ff,
   output arb_pkg::q16_type       box_top_ff,
   output logic [30:0]            box_width_ff,
   output logic [30:0]            box_height_ff
);
   import arb_pkg::*;

   // pair 0: corners 0/1, pair 1: corners 2/3
   q16_type            lo_x_ff [2];
   q16_type            hi_x_ff [2];
   q16_type            lo_y_ff [2];
   q16_type            hi_y_ff [2];
   q16_type            lo_x_in [2];
   q16_type            hi_x_in [2];
   q16_type            lo_y_in [2];
   q16_type            hi_y_in [2];
   q16_type            min_x_ff, max_x_ff, min_y_ff, max_y_ff;
   q16_type            min_x_in, max_x_in, min_y_in, max_y_in;
   logic signed [32:0] dx, dy;
   logic [30:0]        box_width_in, box_height_in;
   logic               v5_ff, v6_ff;

   always_comb begin
      for (int p = 0; p < 2; p++) begin
         lo_x_in[p] = (map_x[2*p] < map_x[2*p+1]) ? map_x[2*p] : map_x[2*p+1];
         hi_x_in[p] = (map_x[2*p] > map_x[2*p+1]) ? map_x[2*p] : map_x[2*p+1];
         lo_y_in[p] = (map_y[2*p] < map_y[2*p+1]) ? map_y[2*p] : map_y[2*p+1];
         hi_y_in[p] = (map_y[2*p] > map_y[2*p+1]) ? map_y[2*p] : map_y[2*p+1];
      end
   end

   always_comb begin
      min_x_in = (lo_x_ff[0] < lo_x_ff[1]) ? lo_x_ff[0] : lo_x_ff[1];
      max_x_in = (hi_x_ff[0] > hi_x_ff[1]) ? hi_x_ff[0] : hi_x_ff[1];
      min_y_in = (lo_y_ff[0] < lo_y_ff[1]) ? lo_y_ff[0] : lo_y_ff[1];
      max_y_in = (hi_y_ff[0] > hi_y_ff[1]) ? hi_y_ff[0] : hi_y_ff[1];
   end

   // difference is never negative; clip to 31 bits
   always_comb begin
      dx            = 33'(max_x_ff) - 33'(min_x_ff);
      dy            = 33'(max_y_ff) - 33'(min_y_ff);
      box_width_in  = (dx[32:31] != 2'b00) ? 31'h7FFF_FFFF : dx[30:0];
      box_height_in = (dy[32:31] != 2'b00) ? 31'h7FFF_FFFF : dy[30:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff    <= 1'b0;
         v6_ff    <= 1'b0;
         valid_ff <= 1'b0;
      end else if (ctl.en) begin
         v5_ff    <= ctl.valid;
         v6_ff    <= v5_ff;
         valid_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         lo_x_ff       <= lo_x_in;
         hi_x_ff       <= hi_x_in;
         lo_y_ff       <= lo_y_in;
         hi_y_ff       <= hi_y_in;
         min_x_ff      <= min_x_in;
         max_x_ff      <= max_x_in;
         min_y_ff      <= min_y_in;
         max_y_ff      <= max_y_in;
         box_left_ff   <= min_x_ff;
         box_top_ff    <= min_y_ff;
         box_width_ff  <= box_width_in;
         box_height_ff <= box_height_in;
      end
   end

endmodule

@@ hdl/affine_rect_bounds_top.sv @@
// Affine rectangle bounds: top level with configuration registers and pipeline control.
// Depends on arb_pkg, arb_corner, arb_mul, arb_map, arb_bbox.
// An accepted req transaction passes through every stage register before rsp_valid.
// Throughput: one transaction per cycle; the seven stages advance together and all
// hold while a result waits on rsp_ready (eight 32x32 multipliers in stage 2).
// Reset: synchronous, clears all stage valid bits and loads the identity transform.
module affine_rect_bounds_top (
   input  logic                   clock,
   input  logic                   reset,
   // configuration write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  arb_pkg::csr_index_type csr_index,
   input  logic [31:0]            csr_data,
   // rectangle in
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [31:0]     req_rect_left,
   input  logic signed [31:0]     req_rect_top,
   input  logic signed [31:0]     req_rect_width,
   input  logic signed [31:0]     req_rect_height,
   // bounding box out
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [31:0]     rsp_box_left,
   output logic signed [31:0]     rsp_box_top,
   output logic [30:0]            rsp_box_width,
   output logic [30:0]            rsp_box_height
);
   import arb_pkg::*;

   coef_type      coef_ff;
   coef_type      coef_in;
   stage_ctl_type ctl;
   logic          s1_valid, s2_valid, s4_valid;
   corner_type    corner;
   prod_type      prod;
   q16_type       map_x [NCORNER];
   q16_type       map_y [NCORNER];

   // Config writes are always taken; out-of-range indexes are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      coef_in = coef_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_COEF_XX:  coef_in.xx    = csr_data;
            CSR_COEF_XY:  coef_in.xy    = csr_data;
            CSR_OFFSET_X: coef_in.off_x = csr_data;
            CSR_COEF_YX:  coef_in.yx    = csr_data;
            CSR_COEF_YY:  coef_in.yy    = csr_data;
            CSR_OFFSET_Y: coef_in.off_y = csr_data;
            default:      coef_in       = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.xx    <= Q16_ONE;
         coef_ff.xy    <= Q16_ZERO;
         coef_ff.off_x <= Q16_ZERO;
         coef_ff.yx    <= Q16_ZERO;
         coef_ff.yy    <= Q16_ONE;
         coef_ff.off_y <= Q16_ZERO;
      end else begin
         coef_ff <= coef_in;
      end
   end

   // Global advance: the whole pipe moves unless the output stage holds an
   // untaken result. Bubbles in earlier stages still move while output is open.
   assign ctl.en    = !rsp_valid || rsp_ready;
   assign ctl.valid = req_valid;
   assign req_ready = ctl.en;

   // stage 1: far edges
   arb_corner u_corner (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .rect_left   (req_rect_left),
      .rect_top    (req_rect_top),
      .rect_width  (req_rect_width),
      .rect_height (req_rect_height),
      .valid_ff    (s1_valid),
      .corner_ff   (corner)
   );

   // stage 2: products
   arb_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .ctl      ('{en: ctl.en, valid: s1_valid}),
      .coef     (coef_ff),
      .corner   (corner),
      .valid_ff (s2_valid),
      .prod_ff  (prod)
   );

   // stages 3-4: mapped corners
   arb_map u_map (
      .clock    (clock),
      .reset    (reset),
      .ctl      ('{en: ctl.en, valid: s2_valid}),
      .coef     (coef_ff),
      .prod     (prod),
      .valid_ff (s4_valid),
      .map_x_ff (map_x),
      .map_y_ff (map_y)
   );

   // stages 5-7: bounding box and output register
   arb_bbox u_bbox (
      .clock         (clock),
      .reset         (reset),
      .ctl           ('{en: ctl.en, valid: s4_valid}),
      .map_x         (map_x),
      .map_y         (map_y),
      .valid_ff      (rsp_valid),
      .box_left_ff   (rsp_box_left),
      .box_top_ff    (rsp_box_top),
      .box_width_ff  (rsp_box_width),
      .box_height_ff (rsp_box_height)
   );

endmodule
